### sv/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared field widths, character codes, opcodes and the cursor step flags of
// the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int TAB_STOP  = 8;

  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic wr_en;
    logic blank;
    logic line_inc;
  } step_t;

endpackage

`default_nettype wire

### sv/tcce_if.sv
// ----------------------------------------------------------------------------
// tcce_if
// Valid/ready channels of the text console cursor engine: one for commands
// and one for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcce_in_if import tcce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  cell_index;

  modport source (output valid, output opcode, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input opcode, input char_code, input cell_index,
                output ready);
endinterface

interface tcce_out_if import tcce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    cell_char;
  logic [ATTR_W-1:0]    cell_attr;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;

  modport source (output valid, output cell_char, output cell_attr, output cursor_col,
                  output cursor_row, input ready);
  modport sink (input valid, input cell_char, input cell_attr, input cursor_col,
                input cursor_row, output ready);
endinterface

`default_nettype wire

### sv/tcce_cursor_step.sv
// ----------------------------------------------------------------------------
// tcce_cursor_step
// Decodes one put byte against the cursor column: next column, the column of
// the cell to write and whether the cursor moves to the next line.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_cursor_step import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  localparam int CW  = $clog2(COLUMNS),
  localparam int CXW = $clog2(COLUMNS + TAB_STOP)
) (
  input  logic [CW-1:0]     col_i,
  input  logic [CHAR_W-1:0] char_i,
  output logic [CW-1:0]     col_o,
  output logic [CW-1:0]     wcol_o,
  output step_t             flags_o
);

  logic [CXW-1:0] col_x;
  logic [CXW-1:0] adv;

  assign col_x = CXW'(col_i);

  always_comb begin
    flags_o = '0;
    wcol_o  = col_i;
    adv     = col_x;
    unique case (char_i)
      CH_NEWLINE: begin
        adv              = '0;
        flags_o.line_inc = 1'b1;
      end
      CH_RETURN: begin
        adv = '0;
      end
      CH_TAB: begin
        adv = (col_x + CXW'(TAB_STOP)) & ~CXW'(TAB_STOP - 1);
      end
      CH_BACKSPACE: begin
        if (col_i != '0) begin
          adv           = col_x - CXW'(1);
          wcol_o        = col_i - CW'(1);
          flags_o.wr_en = 1'b1;
          flags_o.blank = 1'b1;
        end
      end
      default: begin
        adv           = col_x + CXW'(1);
        flags_o.wr_en = 1'b1;
      end
    endcase
    if (adv >= CXW'(COLUMNS)) begin
      col_o            = '0;
      flags_o.line_inc = 1'b1;
    end else begin
      col_o = adv[CW-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/tcce_screen_ram.sv
// ----------------------------------------------------------------------------
// tcce_screen_ram
// Screen cell store: one write port and one read port with registered read
// data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_screen_ram import tcce_pkg::*; #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/tcce_seq.sv
// ----------------------------------------------------------------------------
// tcce_seq
// Command sequencer: cursor, scroll base, fill sweeps, cell reads and the
// result register. Rows are kept in a ring; a scroll moves the ring base and
// blanks the row that becomes the bottom one.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_seq import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int CELLS = COLUMNS * ROWS,
  localparam int AW = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  tcce_in_if.sink           in_ch,
  tcce_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [CELL_W-1:0] mem_rdata
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int XW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_WRITE, S_READ, S_DONE} state_t;

  state_t               state_r;
  logic [ATTR_W-1:0]    attr_r;
  logic [CW-1:0]        col_r;
  logic [RW-1:0]        line_r;
  logic [AW-1:0]        base_r;
  logic [AW-1:0]        sw_addr_r;
  logic [AW-1:0]        sw_end_r;
  logic [ATTR_W-1:0]    sw_attr_r;
  logic                 sw_reply_r;
  logic                 rd_hit_r;
  step_t                step_r;
  logic [CHAR_W-1:0]    ch_r;
  logic [AW-1:0]        lidx_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [ATTR_W-1:0]    out_attr_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [ROW_OUT_W-1:0] out_row_r;

  logic                       accept;
  logic [XW-1:0]              idx_x;
  logic                       rd_hit;
  logic [CW-1:0]              step_col;
  logic [CW-1:0]              step_wcol;
  step_t                      step_flags;
  logic [AW-1:0]              put_lidx;
  logic                       last_line;
  logic                       scroll;
  logic [RW-1:0]              line_new;
  logic                       sweep_last;
  logic                       fin;
  logic                       out_free;
  logic [AW:0]                bsum;
  logic [AW-1:0]              base_next_row;
  logic [CW+COL_OUT_W-1:0]    col_ext;
  logic [RW+ROW_OUT_W-1:0]    row_ext;

  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] lidx,
                                            input logic [AW-1:0] base);
    logic [AW:0] sum;
    sum = {1'b0, lidx} + {1'b0, base};
    if (sum >= (AW+1)'(CELLS)) begin
      sum = sum - (AW+1)'(CELLS);
    end
    return sum[AW-1:0];
  endfunction

  tcce_cursor_step #(.COLUMNS(COLUMNS)) u_step (
    .col_i   (col_r),
    .char_i  (in_ch.char_code),
    .col_o   (step_col),
    .wcol_o  (step_wcol),
    .flags_o (step_flags)
  );

  assign accept     = in_ch.valid && in_ch.ready;
  assign idx_x      = XW'(in_ch.cell_index);
  assign rd_hit     = idx_x < XW'(CELLS);
  assign put_lidx   = AW'(line_r) * AW'(COLUMNS) + AW'(step_wcol);
  assign last_line  = line_r == RW'(ROWS - 1);
  assign scroll     = (state_r == S_WRITE) && step_r.line_inc && last_line;
  assign line_new   = ((state_r == S_WRITE) && step_r.line_inc && !last_line) ?
                      line_r + RW'(1) : line_r;
  assign sweep_last = sw_addr_r == sw_end_r;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign fin        = ((state_r == S_WRITE) && !scroll) || (state_r == S_READ) ||
                      ((state_r == S_SWEEP) && sweep_last && sw_reply_r) ||
                      (state_r == S_DONE);
  assign bsum          = {1'b0, base_r} + (AW+1)'(COLUMNS);
  assign base_next_row = (bsum >= (AW+1)'(CELLS)) ? '0 : bsum[AW-1:0];
  assign col_ext       = (CW+COL_OUT_W)'(col_r);
  assign row_ext       = (RW+ROW_OUT_W)'(line_new);

  assign mem_we    = (state_r == S_SWEEP) || ((state_r == S_WRITE) && step_r.wr_en);
  assign mem_waddr = (state_r == S_SWEEP) ? sw_addr_r : to_phys(lidx_r, base_r);
  assign mem_wdata = (state_r == S_SWEEP) ? {sw_attr_r, CH_BLANK} :
                     {attr_r, (step_r.blank ? CH_BLANK : ch_r)};
  assign mem_re    = accept && (in_ch.opcode == OP_READ) && rd_hit;
  assign mem_raddr = to_phys(idx_x[AW-1:0], base_r);

  assign in_ch.ready       = state_r == S_IDLE;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      attr_r      <= ATTR_RESET;
      col_r       <= '0;
      line_r      <= '0;
      base_r      <= '0;
      sw_addr_r   <= '0;
      sw_end_r    <= AW'(CELLS - 1);
      sw_attr_r   <= ATTR_RESET;
      sw_reply_r  <= 1'b0;
      rd_hit_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (fin && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin) begin
        if (out_free) begin
          out_char_r  <= rd_hit_r ? mem_rdata[CHAR_W-1:0] : '0;
          out_attr_r  <= rd_hit_r ? mem_rdata[CELL_W-1:CHAR_W] : '0;
          out_col_r   <= col_ext[COL_OUT_W-1:0];
          out_row_r   <= row_ext[ROW_OUT_W-1:0];
          state_r     <= S_IDLE;
        end else begin
          state_r <= S_DONE;
        end
      end
      unique case (state_r)
        S_SWEEP: begin
          sw_addr_r <= sw_addr_r + AW'(1);
          if (sweep_last && !sw_reply_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rd_hit_r <= (in_ch.opcode == OP_READ) && rd_hit;
            unique case (in_ch.opcode)
              OP_PUT: begin
                step_r  <= step_flags;
                col_r   <= step_col;
                lidx_r  <= put_lidx;
                ch_r    <= in_ch.char_code;
                state_r <= S_WRITE;
              end
              OP_READ: begin
                state_r  <= S_READ;
              end
              OP_CLEAR: begin
                sw_addr_r  <= '0;
                sw_end_r   <= AW'(CELLS - 1);
                sw_attr_r  <= attr_r;
                sw_reply_r <= 1'b1;
                col_r      <= '0;
                line_r     <= '0;
                base_r     <= '0;
                state_r    <= S_SWEEP;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_WRITE: begin
          line_r <= line_new;
          if (scroll) begin
            sw_addr_r  <= base_r;
            sw_end_r   <= base_r + AW'(COLUMNS - 1);
            sw_attr_r  <= attr_r;
            sw_reply_r <= 1'b1;
            base_r     <= base_next_row;
            state_r    <= S_SWEEP;
          end
        end
        S_READ, S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/text_console_cursor_engine_top.sv
// Every accepted command beat gives one result beat; a put that scrolls first
// blanks the new bottom row, and a clear first blanks the whole screen.
// No new command beat is taken until the result of the last one is registered.
// Reset: synchronous, active low; a fill pass blanks the screen with attribute
// 0x07 while no beat is taken; cursor and attribute reset.
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text console with a screen cell memory, a cursor and row scrolling.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_top import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  tcce_in_if.sink           in_ch,
  tcce_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tcce_seq #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  tcce_screen_ram #(.DEPTH(CELLS)) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  a_busy_after_beat : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("command channel ready right after an accepted beat");

  a_reset_fill : assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready && !out_ch.valid)
    else $error("block not held in the fill pass after reset");

  a_no_early_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !$rose(out_ch.valid))
    else $error("result beat raised in the cycle after a command beat");

endmodule

`default_nettype wire

### bench/text_console_cursor_engine_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top_tb
// Self-checking bench for the text console cursor engine. A driver sends
// command beats from a queue, and a behavioral screen model predicts every
// result beat. A monitor compares each result beat field by field. The run
// mixes directed corner cases with random text streams, reads, clears and
// noise under several text attributes, with random idling on both channels
// and one long result back-pressure stretch.
// ----------------------------------------------------------------------------

module text_console_cursor_engine_top_tb;
  import tcce_pkg::*;

  localparam int COLS   = 80;
  localparam int ROWS_N = 25;
  localparam int CELLS  = COLS * ROWS_N;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
  } result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [ATTR_W-1:0] cfg_wr_data;

  tcce_in_if  in_bus ();
  tcce_out_if out_bus ();

  text_console_cursor_engine_top #(
    .COLUMNS(COLS),
    .ROWS(ROWS_N)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cmd_t        cmd_q[$];
  result_t     result_due[$];
  logic [15:0] screen_model[CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  text_attr;

  bit idle_en;
  int gap_left;
  int stall_left;
  int hold_cycles;
  int n_queued;
  int errs;
  int n_put, n_read, n_clear, n_scroll, n_wrap, n_attr, n_results;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic result_t console_apply(input cmd_t c);
    result_t r;
    int i;
    r = '0;
    case (c.opcode)
      OP_PUT: begin
        n_put++;
        if (c.char_code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (c.char_code == CH_RETURN) begin
          cur_col = 0;
        end else if (c.char_code == CH_TAB) begin
          cur_col = (cur_col + TAB_STOP) / TAB_STOP * TAB_STOP;
        end else if (c.char_code == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_model[cur_row * COLS + cur_col] = {text_attr, CH_BLANK};
          end
        end else begin
          screen_model[cur_row * COLS + cur_col] = {text_attr, c.char_code};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
          n_wrap++;
        end
        if (cur_row >= ROWS_N) begin
          for (i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) screen_model[i] = {text_attr, CH_BLANK};
          cur_row = ROWS_N - 1;
          n_scroll++;
        end
      end
      OP_READ: begin
        n_read++;
        if (c.cell_index < CELLS) begin
          r.cell_char = screen_model[c.cell_index][7:0];
          r.cell_attr = screen_model[c.cell_index][15:8];
        end
      end
      OP_CLEAR: begin
        n_clear++;
        for (i = 0; i < CELLS; i++) screen_model[i] = {text_attr, CH_BLANK};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
      end
    endcase
    r.cursor_col = cur_col[COL_OUT_W-1:0];
    r.cursor_row = cur_row[ROW_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        result_due.push_back(console_apply({in_bus.opcode, in_bus.char_code,
                                            in_bus.cell_index}));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          in_bus.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_q.size() != 0) begin
          nxt = cmd_q.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.opcode <= nxt.opcode;
          in_bus.char_code <= nxt.char_code;
          in_bus.cell_index <= nxt.cell_index;
          if (idle_en && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 18);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.cell_char, out_bus.cell_attr, out_bus.cursor_col, out_bus.cursor_row};
        n_results++;
        if (result_due.size() == 0) begin
          $error("Result beat arrived with nothing expected: %p", got);
          errs++;
        end else begin
          want = result_due.pop_front();
          if (got.cell_char !== want.cell_char) begin
            $error("cell_char mismatch: expected %0d, got %0d", want.cell_char, got.cell_char);
            errs++;
          end
          if (got.cell_attr !== want.cell_attr) begin
            $error("cell_attr mismatch: expected %0d, got %0d", want.cell_attr, got.cell_attr);
            errs++;
          end
          if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col mismatch: expected %0d, got %0d", want.cursor_col,
                   got.cursor_col);
            errs++;
          end
          if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row mismatch: expected %0d, got %0d", want.cursor_row,
                   got.cursor_row);
            errs++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left <= $urandom_range(0, 17);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                          input logic [INDEX_W-1:0] idx);
    cmd_q.push_back('{opcode: op, char_code: ch, cell_index: idx});
    if (op != OP_UNUSED) n_queued++;
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    text_attr = value;
    n_attr++;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (cmd_q.size() != 0 || in_bus.valid || result_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_traffic(input int target);
    int goal, kind, sel, len, k;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    goal = n_queued + target;
    while (n_queued < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) len = $urandom_range(0, 12);
        else if (sel < 9) len = $urandom_range(13, 40);
        else len = $urandom_range(70, 100);
        for (k = 0; k < len; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 80) ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
          else if (sel < 87) ch = CHAR_W'($urandom_range(0, 255));
          else if (sel < 94) ch = CH_TAB;
          else ch = CH_BACKSPACE;
          push_cmd(OP_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
        end
        sel = $urandom_range(0, 9);
        if (sel < 8) push_cmd(OP_PUT, CH_NEWLINE, INDEX_W'($urandom_range(0, 2047)));
        else if (sel < 9) push_cmd(OP_PUT, CH_RETURN, INDEX_W'($urandom_range(0, 2047)));
      end else if (kind < 60) begin
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++) begin
          push_cmd(OP_PUT, CH_NEWLINE, INDEX_W'($urandom_range(0, 2047)));
        end
      end else if (kind < 80) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 50) idx = INDEX_W'($urandom_range(CELLS - 5 * COLS, CELLS - 1));
          else if (sel < 85) idx = INDEX_W'($urandom_range(0, CELLS - 1));
          else idx = INDEX_W'($urandom_range(CELLS, 2047));
          push_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
        end
      end else if (kind < 85) begin
        push_cmd(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                 INDEX_W'($urandom_range(0, 2047)));
      end else if (kind < 87) begin
        push_cmd(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                 INDEX_W'($urandom_range(0, 2047)));
      end else begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          push_cmd(OPCODE_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                   INDEX_W'($urandom_range(0, 2047)));
        end
      end
    end
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = ATTR_RESET;
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_PUT;
    in_bus.char_code = '0;
    in_bus.cell_index = '0;
    out_bus.ready = 1'b0;
    idle_en = 1'b1;
    hold_cycles = 0;
    text_attr = ATTR_RESET;
    for (i = 0; i < CELLS; i++) screen_model[i] = {ATTR_RESET, CH_BLANK};
    cur_col = 0;
    cur_row = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset contents, out-of-range reads, the unused opcode and the control codes.
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'hFF, INDEX_W'(CELLS));
    push_cmd(OP_READ, 8'h00, 11'h7FF);
    push_cmd(OP_UNUSED, 8'hFF, 11'h7FF);
    push_cmd(OP_PUT, CH_BACKSPACE, 11'd0);
    push_cmd(OP_PUT, 8'h41, 11'd0);
    push_cmd(OP_PUT, 8'h00, 11'd0);
    push_cmd(OP_PUT, 8'hFF, 11'd0);
    push_cmd(OP_PUT, CH_TAB, 11'd0);
    push_cmd(OP_PUT, CH_BACKSPACE, 11'd0);
    push_cmd(OP_PUT, CH_RETURN, 11'd0);
    push_cmd(OP_PUT, CH_NEWLINE, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd7);
    wait_quiet();

    // A clear takes the current attribute, and a tab past the last stop wraps.
    set_attribute(8'hFF);
    push_cmd(OP_CLEAR, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_PUT, 8'h7E, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd0);
    for (i = 0; i < 10; i++) push_cmd(OP_PUT, CH_TAB, 11'd0);
    push_cmd(OP_READ, 8'h00, INDEX_W'(CELLS - 1));
    wait_quiet();

    set_attribute(8'h00);
    hold_cycles = 400;
    queue_traffic(150);
    wait_quiet();

    set_attribute(ATTR_W'($urandom_range(0, 255)));
    queue_traffic(150);
    wait_quiet();

    set_attribute(8'hF0);
    queue_traffic(150);
    wait_quiet();

    set_attribute(ATTR_W'($urandom_range(0, 255)));
    idle_en = 1'b0;
    while (gap_left != 0 || stall_left != 0) @(negedge clk);
    queue_traffic(150);
    wait_quiet();
    repeat (200) @(negedge clk);

    $display("Checked %0d result beats: %0d puts, %0d reads, %0d clears.",
             n_results, n_put, n_read, n_clear);
    $display("Screen scrolled %0d times, cursor wrapped %0d times, %0d attribute settings.",
             n_scroll, n_wrap, n_attr);
    if (errs == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
